>>> hdl/tclt_pkg.sv
// ----------------------------------------------------------------------------
// tclt_pkg
// Shared types and fixed field widths of the tile cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tclt_pkg;

  localparam int LEVEL_BITS = 5;
  localparam int SLOT_BITS  = 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_key;
    logic match;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit_now;
    logic is_fill;
    logic scan_last;
  } status_t;

endpackage

`default_nettype wire

>>> hdl/tclt_ctrl.sv
// ----------------------------------------------------------------------------
// tclt_ctrl
// Sequencer of the tag controller: accept, tag match, victim scan, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tclt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire tclt_pkg::status_t status,
  output tclt_pkg::cmd_t        cmd
);

  tclt_pkg::state_t state_r;
  tclt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tclt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tclt_pkg::S_IDLE: begin
        if (start) state_nxt = tclt_pkg::S_MATCH;
      end
      tclt_pkg::S_MATCH: begin
        if (status.hit_now || !status.is_fill) begin
          state_nxt = tclt_pkg::S_DONE;
        end else begin
          state_nxt = tclt_pkg::S_SCAN;
        end
      end
      tclt_pkg::S_SCAN: begin
        if (status.scan_last) state_nxt = tclt_pkg::S_DONE;
      end
      tclt_pkg::S_DONE: begin
        state_nxt = tclt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tclt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      tclt_pkg::S_IDLE: begin
        busy         = 1'b0;
        cmd.load_key = start;
      end
      tclt_pkg::S_MATCH: begin
        cmd.match = 1'b1;
      end
      tclt_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      tclt_pkg::S_DONE: begin
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tclt_datapath.sv
// ----------------------------------------------------------------------------
// tclt_datapath
// Way storage, tag compare, serial least-recently-used scan and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module tclt_datapath #(
  parameter int WAYS       = 4,
  parameter int STAMP_BITS = 32,
  parameter int COORD_BITS = 18
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tclt_pkg::cmd_t                  cmd,
  output tclt_pkg::status_t                    status,
  input  wire logic                            in_kind,
  input  wire logic [tclt_pkg::LEVEL_BITS-1:0] in_level,
  input  wire logic [COORD_BITS-1:0]           in_column,
  input  wire logic [COORD_BITS-1:0]           in_row,
  input  wire logic                            in_load_ok,
  output logic                                 out_strobe,
  output logic                                 out_hit,
  output logic [tclt_pkg::SLOT_BITS-1:0]       out_slot,
  output logic                                 out_resident,
  output logic                                 out_dropped
);

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]                 valid_r;
  logic [tclt_pkg::LEVEL_BITS-1:0] level_r [WAYS];
  logic [COORD_BITS-1:0]           column_r [WAYS];
  logic [COORD_BITS-1:0]           row_r [WAYS];
  logic [STAMP_BITS-1:0]           stamp_r [WAYS];
  logic [STAMP_BITS-1:0]           counter_r;

  logic                            key_kind_r;
  logic [tclt_pkg::LEVEL_BITS-1:0] key_level_r;
  logic [COORD_BITS-1:0]           key_column_r;
  logic [COORD_BITS-1:0]           key_row_r;
  logic                            key_ok_r;

  logic                            hit_r;
  logic [IW-1:0]                   hit_idx_r;
  logic [IW-1:0]                   scan_idx_r;
  logic [IW-1:0]                   best_idx_r;
  logic [STAMP_BITS-1:0]           best_stamp_r;
  logic                            inv_found_r;

  logic                            strobe_r;
  logic                            res_hit_r;
  logic [tclt_pkg::SLOT_BITS-1:0]  res_slot_r;
  logic                            res_resident_r;
  logic                            res_dropped_r;

  logic [WAYS-1:0]                 match;
  logic                            any_hit;
  logic [IW-1:0]                   first_idx;
  logic [STAMP_BITS-1:0]           fresh;
  logic [IW+1:0]                   hit_ext;
  logic [IW+1:0]                   best_ext;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_r[w] && (level_r[w] == key_level_r) &&
                 (column_r[w] == key_column_r) && (row_r[w] == key_row_r);
    end
  end

  always_comb begin
    first_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) first_idx = IW'(w);
    end
  end

  assign any_hit  = |match;
  assign fresh    = counter_r + 1'b1;
  assign hit_ext  = {2'b00, hit_idx_r};
  assign best_ext = {2'b00, best_idx_r};

  assign status.hit_now   = any_hit;
  assign status.is_fill   = key_kind_r;
  assign status.scan_last = (scan_idx_r == IW'(WAYS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_kind_r   <= in_kind;
      key_level_r  <= in_level;
      key_column_r <= in_column;
      key_row_r    <= in_row;
      key_ok_r     <= in_load_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_r        <= any_hit;
      hit_idx_r    <= first_idx;
      scan_idx_r   <= '0;
      best_idx_r   <= '0;
      best_stamp_r <= stamp_r[0];
      inv_found_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (!inv_found_r) begin
        if (!valid_r[scan_idx_r]) begin
          best_idx_r  <= scan_idx_r;
          inv_found_r <= 1'b1;
        end else if (stamp_r[scan_idx_r] < best_stamp_r) begin
          best_idx_r   <= scan_idx_r;
          best_stamp_r <= stamp_r[scan_idx_r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      counter_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.commit;
      if (cmd.commit) begin
        if (hit_r) begin
          counter_r <= fresh;
        end else if (key_kind_r) begin
          valid_r[best_idx_r] <= key_ok_r;
          if (key_ok_r) counter_r <= fresh;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_r) begin
        stamp_r[hit_idx_r] <= fresh;
      end else if (key_kind_r && key_ok_r) begin
        level_r[best_idx_r]  <= key_level_r;
        column_r[best_idx_r] <= key_column_r;
        row_r[best_idx_r]    <= key_row_r;
        stamp_r[best_idx_r]  <= fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_r) begin
        res_hit_r      <= 1'b1;
        res_slot_r     <= hit_ext[1:0];
        res_resident_r <= 1'b1;
        res_dropped_r  <= 1'b0;
      end else if (key_kind_r) begin
        res_hit_r      <= 1'b0;
        res_slot_r     <= best_ext[1:0];
        res_resident_r <= key_ok_r;
        res_dropped_r  <= valid_r[best_idx_r];
      end else begin
        res_hit_r      <= 1'b0;
        res_slot_r     <= '0;
        res_resident_r <= 1'b0;
        res_dropped_r  <= 1'b0;
      end
    end
  end

  assign out_strobe   = strobe_r;
  assign out_hit      = res_hit_r;
  assign out_slot     = res_slot_r;
  assign out_resident = res_resident_r;
  assign out_dropped  = res_dropped_r;

  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(cmd.commit))
    else $error("Result strobe without a commit cycle.");

  a_counter_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (counter_r != $past(counter_r)) |-> $past(cmd.commit))
    else $error("Use counter moved outside a commit cycle.");

  a_hit_resident: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && res_hit_r) |-> (res_resident_r && !res_dropped_r))
    else $error("A hit must report a resident entry and no eviction.");

  a_valid_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(valid_r) |-> $past(cmd.commit && !hit_r && key_kind_r))
    else $error("Valid bits changed outside a fill commit.");

endmodule

`default_nettype wire

>>> hdl/tile_cache_lru_tags_top.sv
// ----------------------------------------------------------------------------
// tile_cache_lru_tags_top
// Tag and least-recently-used replacement controller of a small fully
// associative map-tile cache keyed by zoom level, column and row.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A lookup, or any
// request that hits, keeps busy high through the match and commit states after
// the transfer, so no new request is taken until it is done. A fill that misses
// also passes through the victim scan, which walks the stamps one way at a time
// through a single comparator before the commit. The result is on the out_
// ports for exactly one cycle, marked by out_strobe, in the first cycle with
// busy low again; the receiver cannot stall it and must take the transfer then.
// All ways are invalid after reset, with no clearing pass.
`default_nettype none

module tile_cache_lru_tags_top #(
  parameter int WAYS       = 4,
  parameter int STAMP_BITS = 32,
  parameter int COORD_BITS = 18
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_kind,
  input  wire logic [tclt_pkg::LEVEL_BITS-1:0] in_level,
  input  wire logic [COORD_BITS-1:0]           in_column,
  input  wire logic [COORD_BITS-1:0]           in_row,
  input  wire logic                            in_load_ok,
  output logic                                 out_strobe,
  output logic                                 out_hit,
  output logic [tclt_pkg::SLOT_BITS-1:0]       out_slot,
  output logic                                 out_resident,
  output logic                                 out_dropped
);

  tclt_pkg::cmd_t    cmd;
  tclt_pkg::status_t status;

  tclt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tclt_datapath #(
    .WAYS       (WAYS),
    .STAMP_BITS (STAMP_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_kind      (in_kind),
    .in_level     (in_level),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_load_ok   (in_load_ok),
    .out_strobe   (out_strobe),
    .out_hit      (out_hit),
    .out_slot     (out_slot),
    .out_resident (out_resident),
    .out_dropped  (out_dropped)
  );

endmodule

`default_nettype wire

>>> tb/tile_cache_lru_tags_top_test.sv
// ----------------------------------------------------------------------------
// tile_cache_lru_tags_top_test
// Self-checking testbench of the tile cache tag and LRU replacement controller.
// A queue of tile requests is filled with a directed opening and then random
// requests drawn mostly from a small key pool, so that hits, evictions and
// failed loads recur. A clocked driver presents the requests with random
// gaps. At each transfer the expected result comes from a local model of the
// four tag ways and their use stamps. A clocked monitor checks every strobed
// result, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_cache_lru_tags_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WAYS        = 4;
  localparam int STAMP_BITS  = 32;
  localparam int COORD_BITS  = 18;
  localparam int LEVEL_BITS  = tclt_pkg::LEVEL_BITS;
  localparam int SLOT_BITS   = tclt_pkg::SLOT_BITS;
  localparam int NUM_RANDOM  = 1350;
  localparam int POOL_SIZE   = 6;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                  kind;
    logic [LEVEL_BITS-1:0] level;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic                  load_ok;
    logic                  wait_drain;
  } tile_req_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 resident;
    logic                 dropped;
  } tile_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic [LEVEL_BITS-1:0] in_level = '0;
  logic [COORD_BITS-1:0] in_column = '0;
  logic [COORD_BITS-1:0] in_row = '0;
  logic in_load_ok = 1'b0;
  logic out_strobe;
  logic out_hit;
  logic [SLOT_BITS-1:0] out_slot;
  logic out_resident;
  logic out_dropped;

  tile_req_t pending_reqs[$];
  tile_res_t expected_results[$];
  tile_req_t cur_req;
  int total_reqs = 0;
  int accepted = 0;
  int errors = 0;
  int cycle_count = 0;

  logic                  tag_valid[WAYS];
  logic [LEVEL_BITS-1:0] tag_level[WAYS];
  logic [COORD_BITS-1:0] tag_column[WAYS];
  logic [COORD_BITS-1:0] tag_row[WAYS];
  logic [STAMP_BITS-1:0] tag_stamp[WAYS];
  logic [STAMP_BITS-1:0] stamp_counter;

  tile_cache_lru_tags_top #(
    .WAYS(WAYS),
    .STAMP_BITS(STAMP_BITS),
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_level(in_level),
    .in_column(in_column),
    .in_row(in_row),
    .in_load_ok(in_load_ok),
    .out_strobe(out_strobe),
    .out_hit(out_hit),
    .out_slot(out_slot),
    .out_resident(out_resident),
    .out_dropped(out_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tile_res_t predict_access(tile_req_t rq);
    tile_res_t res;
    int found;
    int victim;
    res = '0;
    found = -1;
    victim = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (found < 0 && tag_valid[w] && tag_level[w] == rq.level &&
          tag_column[w] == rq.column && tag_row[w] == rq.row) begin
        found = w;
      end
    end
    if (found >= 0) begin
      stamp_counter = stamp_counter + 1'b1;
      tag_stamp[found] = stamp_counter;
      res.hit = 1'b1;
      res.slot = found[SLOT_BITS-1:0];
      res.resident = 1'b1;
    end else if (rq.kind) begin
      for (int w = 0; w < WAYS; w++) begin
        if (victim < 0 && !tag_valid[w]) begin
          victim = w;
        end
      end
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (tag_stamp[w] < tag_stamp[victim]) begin
            victim = w;
          end
        end
      end
      res.dropped = tag_valid[victim];
      res.slot = victim[SLOT_BITS-1:0];
      tag_valid[victim] = 1'b0;
      if (rq.load_ok) begin
        stamp_counter = stamp_counter + 1'b1;
        tag_level[victim] = rq.level;
        tag_column[victim] = rq.column;
        tag_row[victim] = rq.row;
        tag_stamp[victim] = stamp_counter;
        tag_valid[victim] = 1'b1;
        res.resident = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void add_req(logic kind, logic [LEVEL_BITS-1:0] level,
                                  logic [COORD_BITS-1:0] column,
                                  logic [COORD_BITS-1:0] row, logic load_ok,
                                  logic wait_drain);
    tile_req_t rq;
    rq.kind = kind;
    rq.level = level;
    rq.column = column;
    rq.row = row;
    rq.load_ok = load_ok;
    rq.wait_drain = wait_drain;
    pending_reqs.push_back(rq);
    total_reqs++;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // The sender idles often in the first third, more in the second, never after.
  always @(posedge clk) begin
    bit taken;
    int idle_pct;
    taken = start && !busy;
    idle_pct = (accepted < total_reqs / 3) ? 34 :
               (accepted < (2 * total_reqs) / 3) ? 74 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        expected_results.push_back(predict_access(cur_req));
        accepted++;
      end
      if (!(start && !taken)) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].wait_drain && expected_results.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          start <= 1'b1;
          in_kind <= cur_req.kind;
          in_level <= cur_req.level;
          in_column <= cur_req.column;
          in_row <= cur_req.row;
          in_load_ok <= cur_req.load_ok;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tile_res_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, hit %0b slot %0d resident %0b dropped %0b",
                 $time, out_hit, out_slot, out_resident, out_dropped);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("hit", want.hit, out_hit);
        check_field("slot", want.slot, out_slot);
        check_field("resident", want.resident, out_resident);
        check_field("dropped", want.dropped, out_dropped);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [LEVEL_BITS-1:0] pool_level[POOL_SIZE];
    logic [COORD_BITS-1:0] pool_column[POOL_SIZE];
    logic [COORD_BITS-1:0] pool_row[POOL_SIZE];
    logic [LEVEL_BITS-1:0] lv;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    int pick;
    for (int w = 0; w < WAYS; w++) begin
      tag_valid[w] = 1'b0;
      tag_level[w] = '0;
      tag_column[w] = '0;
      tag_row[w] = '0;
      tag_stamp[w] = '0;
    end
    stamp_counter = '0;

    add_req(1'b0, 5'd0, 18'd0, 18'd0, 1'b1, 1'b0);
    add_req(1'b1, 5'd0, 18'd0, 18'd0, 1'b0, 1'b0);
    add_req(1'b1, 5'd0, 18'd0, 18'd0, 1'b1, 1'b0);
    add_req(1'b0, 5'd0, 18'd0, 18'd0, 1'b0, 1'b0);
    add_req(1'b1, 5'd31, 18'h3ffff, 18'h3ffff, 1'b1, 1'b0);
    add_req(1'b1, 5'd18, 18'h2aaaa, 18'h15555, 1'b1, 1'b0);
    add_req(1'b1, 5'd5, 18'h15555, 18'h2aaaa, 1'b1, 1'b0);
    add_req(1'b0, 5'd31, 18'h3ffff, 18'h3ffff, 1'b1, 1'b0);
    add_req(1'b1, 5'd0, 18'd0, 18'd0, 1'b1, 1'b0);
    add_req(1'b1, 5'd1, 18'd2, 18'd3, 1'b1, 1'b0);
    add_req(1'b1, 5'd7, 18'd7, 18'd7, 1'b0, 1'b0);
    add_req(1'b0, 5'd7, 18'd7, 18'd7, 1'b0, 1'b0);
    add_req(1'b0, 5'd1, 18'd2, 18'd3, 1'b0, 1'b0);
    add_req(1'b1, 5'd1, 18'd2, 18'd3, 1'b0, 1'b0);
    add_req(1'b0, 5'd0, 18'd0, 18'd1, 1'b0, 1'b0);
    add_req(1'b0, 5'd1, 18'd0, 18'd0, 1'b0, 1'b0);
    add_req(1'b1, 5'd19, 18'h3ffff, 18'd0, 1'b1, 1'b0);
    add_req(1'b1, 5'd30, 18'd0, 18'h3ffff, 1'b1, 1'b0);
    add_req(1'b1, 5'd2, 18'd9, 18'd9, 1'b1, 1'b0);

    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_level[p] = LEVEL_BITS'($urandom_range(31));
      pool_column[p] = COORD_BITS'($urandom());
      pool_row[p] = COORD_BITS'($urandom());
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(39) == 0) begin
        pick = $urandom_range(POOL_SIZE - 1);
        pool_level[pick] = LEVEL_BITS'($urandom_range(31));
        pool_column[pick] = COORD_BITS'($urandom());
        pool_row[pick] = COORD_BITS'($urandom());
      end
      pick = $urandom_range(POOL_SIZE - 1);
      lv = pool_level[pick];
      cx = pool_column[pick];
      cy = pool_row[pick];
      case ($urandom_range(19))
        0: begin
          lv = LEVEL_BITS'($urandom_range(31));
          cx = COORD_BITS'($urandom());
          cy = COORD_BITS'($urandom());
        end
        1: lv[$urandom_range(LEVEL_BITS - 1)] ^= 1'b1;
        2: cx[$urandom_range(COORD_BITS - 1)] ^= 1'b1;
        3: cy[$urandom_range(COORD_BITS - 1)] ^= 1'b1;
        default: ;
      endcase
      add_req(1'($urandom_range(1)), lv, cx, cy, ($urandom_range(4) != 0),
              (i == 0 || i == 600 || i == 1000));
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/tclt_pkg.sv
hdl/tclt_ctrl.sv
hdl/tclt_datapath.sv
hdl/tile_cache_lru_tags_top.sv
tb/tile_cache_lru_tags_top_test.sv
